// File: rtl/tzfs_pkg.sv
// Shared constants, codes and word types for the two-zone free page stack unit.
// Used by tzfs_ctrl, tzfs_datapath and two_zone_free_page_stack_unit.
// No dependencies.
package tzfs_pkg;

   // Geometry of the two stacks and of a page
   localparam int LOW_FRAMES   = 4096;
   localparam int HIGH_FRAMES  = 16384;
   localparam int PAGE_SHIFT   = 12;
   localparam int KB_SHIFT     = 10;

   // Field widths
   localparam int FRAME_W      = 20;
   localparam int ADDR_W       = 32;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 3;
   localparam int LOW_FREE_W   = 13;
   localparam int HIGH_FREE_W  = 15;
   localparam int FIRST_FREE_W = 20;
   localparam int MEM_KB_W     = 22;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 22;

   // Counters hold 0..capacity, indexes 0..capacity-1
   localparam int LOW_CNT_W    = $clog2(LOW_FRAMES + 1);
   localparam int HIGH_CNT_W   = $clog2(HIGH_FRAMES + 1);
   localparam int LOW_IDX_W    = $clog2(LOW_FRAMES);
   localparam int HIGH_IDX_W   = $clog2(HIGH_FRAMES);

   // Low zone ends at the 16 MB boundary
   localparam logic [ADDR_W-1:0] LOW_BOUNDARY = ADDR_W'(64'd16 * 64'd1024 * 64'd1024);
   localparam logic [ADDR_W-1:0] BOUND_FRAMES = LOW_BOUNDARY >> PAGE_SHIFT;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OK_FALLBACK   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOW_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_MEMORY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL    = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_SIZE   = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic              zone;
      logic [ADDR_W-1:0] free_addr;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      alloc_addr;
      logic [STATUS_W-1:0]    status;
      logic [LOW_FREE_W-1:0]  low_free;
      logic [HIGH_FREE_W-1:0] high_free;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic setup;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic fill_done;
   } dp_status_type;

endpackage

// File: rtl/tzfs_ctrl.sv
// Sequencer of the two-zone free page stack unit: accept, init setup and fill, result load.
// Owns the request stall and the result valid register. Depends on tzfs_pkg.
module tzfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [tzfs_pkg::OP_W-1:0] req_op,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  tzfs_pkg::dp_status_type  stat,
   output tzfs_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETUP,
      S_FILL,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Output register can take a new word when empty or draining this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_op == tzfs_pkg::OP_INIT) ? S_SETUP : S_FINISH;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_FILL;
         end
         S_FILL: begin
            if (stat.fill_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result word is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while stalled");

   // Every accepted item ends in exactly one result load before the next accept
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && slot_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("finish did not produce a result word");

   // Fill exits only when both stacks are written
   a_fill_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && !stat.fill_done) |=> (state_ff == S_FILL))
      else $error("fill left early");

endmodule

// File: rtl/tzfs_datapath.sv
// Datapath of the two-zone free page stack unit: stack memories, counts, fill counters,
// configuration registers and the result register. Depends on tzfs_pkg.
module tzfs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tzfs_pkg::ctrl_cmd_type        cmd,
   output tzfs_pkg::dp_status_type       stat,
   input  tzfs_pkg::req_word_type        req_data,
   input  logic                          csr_we,
   input  logic [tzfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tzfs_pkg::CSR_DATA_W-1:0] csr_data,
   output tzfs_pkg::rsp_word_type        rsp_data
);

   localparam int LCW = tzfs_pkg::LOW_CNT_W;
   localparam int HCW = tzfs_pkg::HIGH_CNT_W;
   localparam int LIW = tzfs_pkg::LOW_IDX_W;
   localparam int HIW = tzfs_pkg::HIGH_IDX_W;
   localparam int FW  = tzfs_pkg::FRAME_W;
   localparam int AW  = tzfs_pkg::ADDR_W;
   localparam logic [LCW-1:0] LOW_CAP  = LCW'(tzfs_pkg::LOW_FRAMES);
   localparam logic [HCW-1:0] HIGH_CAP = HCW'(tzfs_pkg::HIGH_FRAMES);

   // Configuration registers
   logic [tzfs_pkg::FIRST_FREE_W-1:0] first_free_ff;
   logic [tzfs_pkg::MEM_KB_W-1:0]     mem_size_kb_ff;

   // Stack memories
   logic [FW-1:0] low_mem  [tzfs_pkg::LOW_FRAMES];
   logic [FW-1:0] high_ram [tzfs_pkg::HIGH_FRAMES];
   logic [FW-1:0] low_rd_ff, high_rd_ff;

   // Counts and fill counters
   logic [LCW-1:0] low_count_ff, low_count_in, low_left_ff, low_left_in;
   logic [HCW-1:0] high_count_ff, high_count_in, high_left_ff, high_left_in;
   logic [FW-1:0]  low_val_ff, low_val_in, high_val_ff, high_val_in;

   // Init bounds latched at accept
   logic [AW-1:0] first_ff, low_end_ff, high_start_ff, total_ff;
   logic [AW-1:0] total, first_ext, low_span, high_span;
   logic [LCW-1:0] low_n;
   logic [HCW-1:0] high_n;

   // Item decode and result bookkeeping
   logic is_alloc, is_free, is_init, free_low;
   logic take_low, take_high, push_low, push_high;
   logic hit_low_ff, hit_high_ff;
   logic [tzfs_pkg::STATUS_W-1:0] status_in, status_ff;
   logic [FW-1:0]  free_frame;
   logic [LCW-1:0] low_dec, low_left_dec;
   logic [HCW-1:0] high_dec, high_left_dec;
   logic           low_we, high_we;
   logic [LIW-1:0] low_waddr;
   logic [HIW-1:0] high_waddr;
   logic [FW-1:0]  low_wdata, high_wdata;
   tzfs_pkg::rsp_word_type rsp_data_ff;

   // Decode the accepted word
   assign is_alloc   = cmd.accept && (req_data.operation == tzfs_pkg::OP_ALLOC);
   assign is_free    = cmd.accept && (req_data.operation == tzfs_pkg::OP_FREE);
   assign is_init    = cmd.accept && (req_data.operation == tzfs_pkg::OP_INIT);
   assign take_high  = is_alloc && req_data.zone && (high_count_ff != '0);
   assign take_low   = is_alloc && !take_high && (low_count_ff != '0);
   assign free_low   = req_data.free_addr < tzfs_pkg::LOW_BOUNDARY;
   assign push_low   = is_free && free_low && (low_count_ff < LOW_CAP);
   assign push_high  = is_free && !free_low && (high_count_ff < HIGH_CAP);
   assign free_frame = FW'(req_data.free_addr >> tzfs_pkg::PAGE_SHIFT);

   assign low_dec       = low_count_ff - 1'b1;
   assign high_dec      = high_count_ff - 1'b1;
   assign low_left_dec  = low_left_ff - 1'b1;
   assign high_left_dec = high_left_ff - 1'b1;

   // Status of the accepted word
   always_comb begin
      status_in = tzfs_pkg::ST_OK;
      if (is_alloc) begin
         if (take_low && req_data.zone) begin
            status_in = tzfs_pkg::ST_OK_FALLBACK;
         end else if (!take_low && !take_high) begin
            status_in = req_data.zone ? tzfs_pkg::ST_OUT_OF_MEMORY
                                      : tzfs_pkg::ST_LOW_EXHAUSTED;
         end
      end else if (is_free && !push_low && !push_high) begin
         status_in = tzfs_pkg::ST_STACK_FULL;
      end
   end

   // Init bounds: total frames, low end and high start
   assign total     = (AW'(mem_size_kb_ff) << tzfs_pkg::KB_SHIFT) >> tzfs_pkg::PAGE_SHIFT;
   assign first_ext = AW'(first_free_ff);

   // Zone sizes, capped at stack capacity
   assign low_span  = (low_end_ff > first_ff) ? (low_end_ff - first_ff) : '0;
   assign high_span = (total_ff > high_start_ff) ? (total_ff - high_start_ff) : '0;
   assign low_n     = (low_span > AW'(tzfs_pkg::LOW_FRAMES)) ? LOW_CAP : LCW'(low_span);
   assign high_n    = (high_span > AW'(tzfs_pkg::HIGH_FRAMES)) ? HIGH_CAP : HCW'(high_span);

   // Next counts and fill counters
   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      low_left_in   = low_left_ff;
      high_left_in  = high_left_ff;
      low_val_in    = low_val_ff;
      high_val_in   = high_val_ff;
      if (take_low)  low_count_in  = low_dec;
      if (push_low)  low_count_in  = low_count_ff + 1'b1;
      if (take_high) high_count_in = high_dec;
      if (push_high) high_count_in = high_count_ff + 1'b1;
      if (cmd.setup) begin
         low_count_in  = low_n;
         high_count_in = high_n;
         low_left_in   = low_n;
         high_left_in  = high_n;
         low_val_in    = FW'(first_ff);
         high_val_in   = FW'(high_start_ff);
      end else begin
         if (low_left_ff != '0) begin
            low_left_in = low_left_dec;
            low_val_in  = low_val_ff + 1'b1;
         end
         if (high_left_ff != '0) begin
            high_left_in = high_left_dec;
            high_val_in  = high_val_ff + 1'b1;
         end
      end
   end

   assign stat.fill_done = (low_left_ff == '0) && (high_left_ff == '0);

   // Memory write ports: push on free, lowest frame lands on top on fill
   assign low_we     = push_low || (low_left_ff != '0);
   assign low_waddr  = push_low ? low_count_ff[LIW-1:0] : low_left_dec[LIW-1:0];
   assign low_wdata  = push_low ? free_frame : low_val_ff;
   assign high_we    = push_high || (high_left_ff != '0);
   assign high_waddr = push_high ? high_count_ff[HIW-1:0] : high_left_dec[HIW-1:0];
   assign high_wdata = push_high ? free_frame : high_val_ff;

   // Low stack memory
   always_ff @(posedge clock) begin
      if (low_we) begin
         low_mem[low_waddr] <= low_wdata;
      end
      if (take_low) begin
         low_rd_ff <= low_mem[low_dec[LIW-1:0]];
      end
   end

   // High stack memory
   always_ff @(posedge clock) begin
      if (high_we) begin
         high_ram[high_waddr] <= high_wdata;
      end
      if (take_high) begin
         high_rd_ff <= high_ram[high_dec[HIW-1:0]];
      end
   end

   // Control registers: counts, fill counters, configuration, hit flags
   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff   <= '0;
         high_count_ff  <= '0;
         low_left_ff    <= '0;
         high_left_ff   <= '0;
         first_free_ff  <= '0;
         mem_size_kb_ff <= '0;
         hit_low_ff     <= 1'b0;
         hit_high_ff    <= 1'b0;
      end else begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
         low_left_ff   <= low_left_in;
         high_left_ff  <= high_left_in;
         if (cmd.accept) begin
            hit_low_ff  <= take_low;
            hit_high_ff <= take_high;
         end
         if (csr_we) begin
            unique case (csr_index)
               tzfs_pkg::CSR_FIRST_FREE:
                  first_free_ff <= csr_data[tzfs_pkg::FIRST_FREE_W-1:0];
               tzfs_pkg::CSR_MEM_SIZE:
                  mem_size_kb_ff <= csr_data[tzfs_pkg::MEM_KB_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers: fill values, init bounds, status, result word
   always_ff @(posedge clock) begin
      low_val_ff  <= low_val_in;
      high_val_ff <= high_val_in;
      if (cmd.accept) begin
         status_ff <= status_in;
      end
      if (is_init) begin
         first_ff      <= first_ext;
         total_ff      <= total;
         low_end_ff    <= (total < tzfs_pkg::BOUND_FRAMES) ? total : tzfs_pkg::BOUND_FRAMES;
         high_start_ff <= (first_ext > tzfs_pkg::BOUND_FRAMES) ? first_ext
                                                               : tzfs_pkg::BOUND_FRAMES;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.alloc_addr <= hit_high_ff ? (AW'(high_rd_ff) << tzfs_pkg::PAGE_SHIFT)
                                 : hit_low_ff  ? (AW'(low_rd_ff) << tzfs_pkg::PAGE_SHIFT)
                                 : '0;
         rsp_data_ff.status     <= status_ff;
         rsp_data_ff.low_free   <= tzfs_pkg::LOW_FREE_W'(low_count_ff);
         rsp_data_ff.high_free  <= tzfs_pkg::HIGH_FREE_W'(high_count_ff);
      end
   end

   assign rsp_data = rsp_data_ff;

   // Counts never pass capacity
   a_low_cap: assert property (@(posedge clock) disable iff (reset)
      low_count_ff <= LOW_CAP)
      else $error("low count above capacity");

   a_high_cap: assert property (@(posedge clock) disable iff (reset)
      high_count_ff <= HIGH_CAP)
      else $error("high count above capacity");

   // Fill writes only below the count it set
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (low_left_ff <= low_count_ff) && (high_left_ff <= high_count_ff))
      else $error("fill pointer beyond stack count");

   // A low pop lowers the low count by one
   a_low_pop: assert property (@(posedge clock) disable iff (reset)
      take_low |=> (low_count_ff == $past(low_dec)))
      else $error("low pop did not decrement count");

endmodule

// File: rtl/two_zone_free_page_stack_unit.sv
// Two-zone free page stack unit: top level joining the sequencer and the datapath.
// Depends on tzfs_pkg, tzfs_ctrl and tzfs_datapath.
//
// Usage:
//   req_valid/req_stall/req_data carry one command word: allocate (zone 0 low only,
//   zone 1 high with low fallback), free (free_addr picks the stack), or init.
//   rsp_valid/rsp_stall/rsp_data return exactly one word per command with the
//   allocated address, a status code and both free counts after the command.
//   csr_valid/csr_ready/csr_index/csr_data write first_free_frame (index 0) and
//   mem_size_kb (index 1); csr_ready is always high. Write them only while idle.
// Sequence:
//   Allocate, free and the unused code: the accept reads or writes the stack, the
//   finish state loads the result word once the output register is free, then a new accept.
//   Init steps through the accept, a setup state, a fill state that writes one frame per
//   cycle into both stacks in parallel until both fill counters reach zero, then the
//   result load.
//   A new command is accepted while the previous result still waits in the output
//   register; a stalled receiver holds that word and blocks the next result load.
// Reset:
//   Synchronous, active high. Both counts and both configuration registers clear,
//   so every allocate fails until an init or a free. Stack contents are not cleared.
module two_zone_free_page_stack_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tzfs_pkg::req_word_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tzfs_pkg::rsp_word_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tzfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tzfs_pkg::CSR_DATA_W-1:0] csr_data
);

   tzfs_pkg::ctrl_cmd_type  cmd;
   tzfs_pkg::dp_status_type stat;
   logic                    csr_we;

   // Always take configuration words
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   tzfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tzfs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
